FILE: src/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// Command codes, opcodes and small helpers shared by the accumulator machine
// core and its channel interfaces.
// ----------------------------------------------------------------------------
package amc_pkg;

   typedef logic [1:0]  cmd_type;
   typedef logic [7:0]  byte_type;
   typedef logic [31:0] word_type;

   // commands
   localparam cmd_type CMD_WRITE = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_START = 2'd2;
   localparam cmd_type CMD_EXEC  = 2'd3;

   // opcodes
   localparam byte_type OP_HALT     = 8'h00;
   localparam byte_type OP_LOAD     = 8'h01;
   localparam byte_type OP_LOADNEG  = 8'h02;
   localparam byte_type OP_LOADABS  = 8'h03;
   localparam byte_type OP_LOADNABS = 8'h04;
   localparam byte_type OP_ADD      = 8'h05;
   localparam byte_type OP_SUB      = 8'h06;
   localparam byte_type OP_ADDABS   = 8'h07;
   localparam byte_type OP_SUBABS   = 8'h08;
   localparam byte_type OP_JMPL     = 8'h0D;
   localparam byte_type OP_JMPR     = 8'h0E;
   localparam byte_type OP_JMPPL    = 8'h0F;
   localparam byte_type OP_JMPPR    = 8'h10;
   localparam byte_type OP_STADDRL  = 8'h12;
   localparam byte_type OP_STADDRR  = 8'h13;
   localparam byte_type OP_STORE    = 8'h21;

   // two's complement magnitude, wraps for the most negative value
   function automatic word_type magnitude(input word_type v);
      return v[31] ? word_type'(32'd0 - v) : v;
   endfunction

endpackage

FILE: src/amc_ifs.sv
// ----------------------------------------------------------------------------
// amc channel interfaces
// Valid/ready channels for commands into and results out of the core.
// ----------------------------------------------------------------------------
interface amc_req_if import amc_pkg::*; ();
   logic     valid;
   logic     ready;
   cmd_type  cmd;
   byte_type addr;
   word_type data;

   modport source (output valid, output cmd, output addr, output data, input ready);
   modport sink (input valid, input cmd, input addr, input data, output ready);
endinterface

interface amc_rsp_if import amc_pkg::*; ();
   logic            valid;
   logic            ready;
   word_type        read_data;
   logic signed [31:0] acc;
   byte_type        pc;
   logic            halted;

   modport source (output valid, output read_data, output acc, output pc, output halted,
                   input ready);
   modport sink (input valid, input read_data, input acc, input pc, input halted,
                 output ready);
endinterface

FILE: src/accumulator_machine_core.sv
// ----------------------------------------------------------------------------
// accumulator_machine_core
// Stored-program accumulator machine, two instructions per memory word.
// ----------------------------------------------------------------------------
// Every command gives exactly one result transfer. All work runs through a
// single-port main store with registered read data. Write, read, start and
// an execute while halted go straight to the finish state; an execute of a
// right half steps through operand read and execute, an execute of a left
// half through instruction fetch, operand read and execute, and a taken
// jump to a right half adds a step for the target fetch. The result
// register is loaded in the finish state, in the same cycle in which the
// next command is taken. A result left waiting there stalls the core only
// once the next result is ready to be loaded. The store reads as zero after
// reset through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module accumulator_machine_core import amc_pkg::*; #(
   parameter int MEM_WORDS = 256
) (
   input  logic      clock,
   input  logic      reset,
   amc_req_if.sink   req_ch,
   amc_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(MEM_WORDS);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_FETCH   = 3'd1;
   localparam logic [2:0] ST_EXEC    = 3'd2;
   localparam logic [2:0] ST_REFETCH = 3'd3;
   localparam logic [2:0] ST_FIN     = 3'd4;

   // byte address to word index, worked out at elaboration
   logic [AW-1:0] mod_tab [256];
   for (genvar i = 0; i < 256; i++) begin : g_mod
      assign mod_tab[i] = AW'(i % MEM_WORDS);
   end

   // main store
   word_type              mem [MEM_WORDS];
   logic [MEM_WORDS-1:0]  valid_ff;
   word_type              rdata_ff;
   logic                  rvalid_ff;

   logic     mem_en, mem_we;
   byte_type mem_addr8;
   word_type mem_wdata;
   logic [AW-1:0] word_idx;
   word_type word;

   logic [2:0] state_ff, state_in;
   byte_type   pc_ff, pc_in;
   word_type   acc_ff, acc_in;
   logic [15:0] rhb_ff, rhb_in;
   byte_type   opcode_ff, opcode_in;
   byte_type   opaddr_ff, opaddr_in;
   logic       rp_ff, rp_in;
   logic       halt_ff, halt_in;
   logic       rdsel_ff, rdsel_in;

   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_read_data_ff, rsp_read_data_in;
   word_type   rsp_acc_ff, rsp_acc_in;
   byte_type   rsp_pc_ff, rsp_pc_in;
   logic       rsp_halted_ff, rsp_halted_in;

   logic     rsp_free, rsp_load, req_fire;
   word_type mag_m;

   assign word_idx = mod_tab[mem_addr8];
   assign word     = rvalid_ff ? rdata_ff : '0;
   assign mag_m    = magnitude(word);

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) || (state_ff == ST_FIN && rsp_free);
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      rhb_in    = rhb_ff;
      opcode_in = opcode_ff;
      opaddr_in = opaddr_ff;
      rp_in     = rp_ff;
      halt_in   = halt_ff;
      rdsel_in  = rdsel_ff;
      mem_en    = 1'b0;
      mem_we    = 1'b0;
      mem_addr8 = pc_ff;
      mem_wdata = acc_ff;
      rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FETCH: begin
            // left half runs now, right half waits in the buffer
            rhb_in    = word[15:0];
            opcode_in = word[31:24];
            opaddr_in = word[23:16];
            mem_en    = 1'b1;
            mem_addr8 = word[23:16];
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_FIN;
            unique case (opcode_ff)
               OP_HALT:     halt_in = 1'b1;
               OP_LOAD:     acc_in = word;
               OP_LOADNEG:  acc_in = 32'd0 - word;
               OP_LOADABS:  acc_in = mag_m;
               OP_LOADNABS: acc_in = 32'd0 - mag_m;
               OP_ADD:      acc_in = acc_ff + word;
               OP_SUB:      acc_in = acc_ff - word;
               OP_ADDABS:   acc_in = acc_ff + mag_m;
               OP_SUBABS:   acc_in = acc_ff - mag_m;
               OP_STORE: begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr8 = opaddr_ff;
                  mem_wdata = acc_ff;
               end
               OP_STADDRL: begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr8 = opaddr_ff;
                  mem_wdata = {word[31:24], acc_ff[7:0], word[15:0]};
               end
               OP_STADDRR: begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr8 = opaddr_ff;
                  mem_wdata = {word[31:8], acc_ff[7:0]};
               end
               OP_JMPL: begin
                  pc_in = opaddr_ff;
                  rp_in = 1'b0;
               end
               OP_JMPPL: begin
                  if (!acc_ff[31]) begin
                     pc_in = opaddr_ff;
                     rp_in = 1'b0;
                  end
               end
               OP_JMPR: begin
                  pc_in     = opaddr_ff;
                  rp_in     = 1'b1;
                  mem_en    = 1'b1;
                  mem_addr8 = opaddr_ff;
                  state_in  = ST_REFETCH;
               end
               OP_JMPPR: begin
                  if (!acc_ff[31]) begin
                     pc_in     = opaddr_ff;
                     rp_in     = 1'b1;
                     mem_en    = 1'b1;
                     mem_addr8 = opaddr_ff;
                     state_in  = ST_REFETCH;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_REFETCH: begin
            rhb_in    = word[15:0];
            opcode_in = word[31:24];
            opaddr_in = word[23:16];
            state_in  = ST_FIN;
         end
         default: state_in = ST_IDLE;
      endcase

      // a new transfer may start in the cycle the previous result is loaded
      if (req_fire) begin
         rdsel_in = (req_ch.cmd == CMD_READ);
         state_in = ST_FIN;
         unique case (req_ch.cmd)
            CMD_WRITE: begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_addr8 = req_ch.addr;
               mem_wdata = req_ch.data;
            end
            CMD_READ: begin
               mem_en    = 1'b1;
               mem_addr8 = req_ch.addr;
            end
            CMD_START: begin
               pc_in   = req_ch.addr;
               halt_in = 1'b0;
               rp_in   = 1'b0;
            end
            CMD_EXEC: begin
               if (!halt_ff) begin
                  mem_en = 1'b1;
                  if (rp_ff) begin
                     opcode_in = rhb_ff[15:8];
                     opaddr_in = rhb_ff[7:0];
                     pc_in     = 8'(pc_ff + 8'd1);
                     rp_in     = 1'b0;
                     mem_addr8 = rhb_ff[7:0];
                     state_in  = ST_EXEC;
                  end else begin
                     mem_addr8 = pc_ff;
                     rp_in     = 1'b1;
                     state_in  = ST_FETCH;
                  end
               end
            end
         endcase
      end

      rsp_valid_in     = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
      rsp_read_data_in = rsp_read_data_ff;
      rsp_acc_in       = rsp_acc_ff;
      rsp_pc_in        = rsp_pc_ff;
      rsp_halted_in    = rsp_halted_ff;
      if (rsp_load) begin
         rsp_read_data_in = rdsel_ff ? word : '0;
         rsp_acc_in       = acc_ff;
         rsp_pc_in        = pc_ff;
         rsp_halted_in    = halt_ff;
      end
   end

   // store array, single port
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            mem[word_idx] <= mem_wdata;
         end else begin
            rdata_ff <= mem[word_idx];
         end
      end
   end

   // words never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else if (mem_en) begin
         if (mem_we) begin
            valid_ff[word_idx] <= 1'b1;
         end else begin
            rvalid_ff <= valid_ff[word_idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         rhb_ff       <= '0;
         opcode_ff    <= '0;
         opaddr_ff    <= '0;
         rp_ff        <= 1'b0;
         halt_ff      <= 1'b0;
         rdsel_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         rhb_ff       <= rhb_in;
         opcode_ff    <= opcode_in;
         opaddr_ff    <= opaddr_in;
         rp_ff        <= rp_in;
         halt_ff      <= halt_in;
         rdsel_ff     <= rdsel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_acc_ff       <= rsp_acc_in;
      rsp_pc_ff        <= rsp_pc_in;
      rsp_halted_ff    <= rsp_halted_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_read_data_ff;
   assign rsp_ch.acc       = signed'(rsp_acc_ff);
   assign rsp_ch.pc        = rsp_pc_ff;
   assign rsp_ch.halted    = rsp_halted_ff;

   a_accept_state: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (state_ff == ST_IDLE || state_ff == ST_FIN))
      else $error("transfer taken while an item is in flight");

   a_fetch_to_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_EXEC))
      else $error("instruction fetch not followed by execute");

   a_halt_sets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && opcode_ff == OP_HALT) |=> halt_ff)
      else $error("halt opcode did not set the halt flag");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_load) |=> (rsp_valid_ff && rsp_pc_ff == $past(pc_ff)))
      else $error("result register not loaded with current state");

   a_store_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff == ST_EXEC) |-> !req_fire)
      else $error("store and new command share the memory port");

endmodule
